// ----- sv/tdq_pkg.sv -----
// tdq_pkg: shared types, register codes and constants of the dither quantiser
// also holds the seed generator used to load the per-channel dither seeds
// no dependencies
package tdq_pkg;

   localparam logic [31:0] SEED_START   = 32'h3141_5926;
   localparam logic [4:0]  MAX_WIDTH    = 5'd24;
   localparam logic [2:0]  MAX_BYTES    = 3'd4;
   localparam int          QUEUE_DEPTH  = 2;
   localparam int          CSR_IDX_W    = 3;
   localparam int          CSR_DATA_W   = 16;

   localparam logic [4:0]  RST_OUTPUT_WIDTH    = 5'd16;
   localparam logic [2:0]  RST_CONTAINER_BYTES = 3'd2;
   localparam logic [15:0] RST_GAIN            = 16'd16384;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_WIDTH    = 3'd0,
      CSR_CONTAINER_BYTES = 3'd1,
      CSR_GAIN            = 3'd2,
      CSR_DITHER_ENABLE   = 3'd3,
      CSR_DITHER_MODE     = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      DM_FLAT     = 2'd0,
      DM_LOWPASS  = 2'd1,
      DM_HIGHPASS = 2'd2,
      DM_SPARE    = 2'd3
   } dither_mode_type;

   typedef struct packed {
      logic signed [31:0] sample;
      logic [2:0]         channel;
      logic               block_end;
   } req_type;

   typedef struct packed {
      logic [31:0] container_word;
      logic        clipped;
      logic [15:0] block_clips;
   } rsp_type;

   typedef struct packed {
      logic [4:0]      output_width;
      logic [2:0]      container_bytes;
      logic [15:0]     gain;
      logic            dither_enable;
      dither_mode_type dither_mode;
   } cfg_type;

   // one classified sample between front and back
   typedef struct packed {
      logic signed [47:0] product;
      logic signed [31:0] dither;
      logic [4:0]         bits;
      logic [2:0]         nbytes;
      logic [1:0]         pre;
      logic [2:0]         jshift;
      logic               offset;
      logic               last;
   } work_type;

   function automatic logic [31:0] lcg_step(input logic [31:0] r);
      return ((r << 4) - r) ^ 32'd1;
   endfunction

   function automatic logic [31:0] seed_at(input int idx);
      logic [31:0] r;
      logic [31:0] w;
      r = SEED_START;
      w = '0;
      for (int i = 0; i <= idx; i++) begin
         w = '0;
         for (int k = 0; k < 4; k++) begin
            w[8*k +: 8] = r[31:24];
            r = lcg_step(lcg_step(lcg_step(r)));
         end
      end
      return w;
   endfunction

endpackage

// ----- sv/tdq_front.sv -----
// tdq_front: accepts samples, runs the per-channel dither generators,
// forms sample times gain and classifies the output format
// depends on tdq_pkg
module tdq_front #(
   parameter int CHANNELS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  tdq_pkg::req_type  req_payload,
   input  tdq_pkg::cfg_type  cfg,
   output logic              push_valid,
   input  logic              push_ready,
   output tdq_pkg::work_type push_work
);

   localparam int NSEED = (CHANNELS < 8) ? CHANNELS : 8;
   localparam int IDX_W = (NSEED > 1) ? $clog2(NSEED) : 1;

   logic                 front_valid_ff, front_valid_in;
   tdq_pkg::work_type    work_ff, work_in;
   logic [31:0]          seed_ff [NSEED];
   logic                 accept;
   logic                 ch_ok;
   logic                 do_dither;
   logic [IDX_W-1:0]     idx;
   logic [31:0]          old_seed, r2, r5, partner, dsum;
   logic signed [48:0]   prod_full;
   logic [4:0]           bits;
   logic [2:0]           nbytes, cbytes;

   assign accept    = req_valid && req_ready;
   assign req_ready = !front_valid_ff || push_ready;
   assign idx       = req_payload.channel[IDX_W-1:0];
   assign ch_ok     = 32'(req_payload.channel) < 32'(NSEED);
   assign do_dither = cfg.dither_enable && ch_ok;

   always_comb begin
      old_seed = ch_ok ? seed_ff[idx] : '0;
      r2       = tdq_pkg::lcg_step(tdq_pkg::lcg_step(old_seed));
      r5       = tdq_pkg::lcg_step(tdq_pkg::lcg_step(tdq_pkg::lcg_step(r2)));
      case (cfg.dither_mode)
         tdq_pkg::DM_LOWPASS:  partner = old_seed;
         tdq_pkg::DM_HIGHPASS: partner = ~old_seed;
         default:              partner = ~r2;
      endcase
      dsum = {1'b0, partner[31:1]} + {1'b0, r5[31:1]};
   end

   generate
      for (genvar g = 0; g < NSEED; g++) begin : g_seed
         localparam logic [31:0] SeedInit = tdq_pkg::seed_at(g);
         always_ff @(posedge clock) begin
            if (reset) begin
               seed_ff[g] <= SeedInit;
            end else if (accept && do_dither && (idx == IDX_W'(g))) begin
               seed_ff[g] <= r5;
            end
         end
      end
   endgenerate

   assign prod_full = req_payload.sample * $signed({1'b0, cfg.gain});

   always_comb begin
      bits = cfg.output_width;
      if (bits == 5'd0) begin
         bits = 5'd1;
      end else if (bits > tdq_pkg::MAX_WIDTH) begin
         bits = tdq_pkg::MAX_WIDTH;
      end
      nbytes = 3'((6'(bits) + 6'd7) >> 3);
      cbytes = cfg.container_bytes;
      if (cbytes < nbytes) begin
         cbytes = nbytes;
      end
      if (cbytes > tdq_pkg::MAX_BYTES) begin
         cbytes = tdq_pkg::MAX_BYTES;
      end
      work_in.product = prod_full[47:0];
      // sum of two halves minus 2^31: flip the top bit
      work_in.dither  = do_dither ? $signed({~dsum[31], dsum[30:0]}) : 32'sd0;
      work_in.bits    = bits;
      work_in.nbytes  = nbytes;
      work_in.pre     = 2'(cbytes - nbytes);
      work_in.jshift  = 3'(tdq_pkg::MAX_WIDTH - bits);
      work_in.offset  = bits <= 5'd8;
      work_in.last    = req_payload.block_end;
   end

   always_comb begin
      front_valid_in = front_valid_ff;
      if (accept) begin
         front_valid_in = 1'b1;
      end else if (push_ready) begin
         front_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         work_ff <= work_in;
      end
   end

   assign push_valid = front_valid_ff;
   assign push_work  = work_ff;

endmodule

// ----- sv/tdq_queue.sv -----
// tdq_queue: short first-in first-out queue of classified samples
// decouples the front from the back
// depends on tdq_pkg
module tdq_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  tdq_pkg::work_type push_work,
   output logic              pop_valid,
   input  logic              pop_ready,
   output tdq_pkg::work_type pop_work
);

   localparam int PTR_W = $clog2(tdq_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(tdq_pkg::QUEUE_DEPTH + 1);

   tdq_pkg::work_type mem [tdq_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CNT_W'(tdq_pkg::QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_work   = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(tdq_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(tdq_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_work;
      end
   end

endmodule

// ----- sv/tdq_back.sv -----
// tdq_back: scales, adds dither, rounds, clips and packs each sample
// keeps the block clip count and holds the result register
// depends on tdq_pkg
module tdq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  tdq_pkg::work_type pop_work,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output tdq_pkg::rsp_type  rsp_payload
);

   logic               rsp_valid_ff, rsp_valid_in;
   tdq_pkg::rsp_type   rsp_ff, rsp_in;
   logic [15:0]        clips_ff, clips_in, clips_next;
   logic               pop;
   logic signed [71:0] scaled, dith_term, total;
   logic signed [29:0] v, vc, hi_lim, lo_lim;
   logic               clip;
   logic [31:0]        code, mask;

   assign pop_ready = !rsp_valid_ff || rsp_ready;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      scaled    = 72'(pop_work.product) <<< (pop_work.bits - 5'd1);
      dith_term = 72'(pop_work.dither) <<< 11;
      total     = scaled + dith_term + (72'sd1 <<< 41);
      v         = $signed(total[71:42]);
      hi_lim    = (30'sd1 <<< (pop_work.bits - 5'd1)) - 30'sd1;
      lo_lim    = -(30'sd1 <<< (pop_work.bits - 5'd1));
      clip      = 1'b0;
      vc        = v;
      if (v > hi_lim) begin
         vc   = hi_lim;
         clip = 1'b1;
      end else if (v < lo_lim) begin
         vc   = lo_lim;
         clip = 1'b1;
      end
      code = (32'(vc) << pop_work.jshift) + (pop_work.offset ? 32'd128 : 32'd0);
      case (pop_work.nbytes)
         3'd1:    mask = 32'h0000_00FF;
         3'd2:    mask = 32'h0000_FFFF;
         default: mask = 32'h00FF_FFFF;
      endcase
      clips_next = (clip && (clips_ff != 16'hFFFF)) ? clips_ff + 16'd1 : clips_ff;
      clips_in   = pop_work.last ? 16'd0 : clips_next;
      rsp_in.container_word = (code & mask) << {pop_work.pre, 3'b000};
      rsp_in.clipped        = clip;
      rsp_in.block_clips    = pop_work.last ? clips_next : 16'd0;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         clips_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            clips_ff <= clips_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ----- sv/tpdf_dither_quantizer.sv -----
// tpdf_dither_quantizer: triangular-dither requantiser with container packing
// path from the accepting edge to the result shown: front register,
// queue, result register; one transaction per cycle sustained while results are taken
// the front accepts while its register is free or the queue has room,
// the back moves while the result is free or being taken
// synchronous reset restores the register defaults, the dither seeds and a zero clip count
module tpdf_dither_quantizer #(
   parameter int CHANNELS = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  tdq_pkg::req_type                 req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output tdq_pkg::rsp_type                 rsp_payload,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tdq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tdq_pkg::CSR_DATA_W-1:0]   csr_data
);

   tdq_pkg::cfg_type  cfg_ff;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   tdq_pkg::work_type push_work, pop_work;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.output_width    <= tdq_pkg::RST_OUTPUT_WIDTH;
         cfg_ff.container_bytes <= tdq_pkg::RST_CONTAINER_BYTES;
         cfg_ff.gain            <= tdq_pkg::RST_GAIN;
         cfg_ff.dither_enable   <= 1'b0;
         cfg_ff.dither_mode     <= tdq_pkg::DM_FLAT;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tdq_pkg::CSR_OUTPUT_WIDTH:    cfg_ff.output_width    <= csr_data[4:0];
            tdq_pkg::CSR_CONTAINER_BYTES: cfg_ff.container_bytes <= csr_data[2:0];
            tdq_pkg::CSR_GAIN:            cfg_ff.gain            <= csr_data;
            tdq_pkg::CSR_DITHER_ENABLE:   cfg_ff.dither_enable   <= csr_data[0];
            tdq_pkg::CSR_DITHER_MODE:
               cfg_ff.dither_mode <= tdq_pkg::dither_mode_type'(csr_data[1:0]);
            default: ;
         endcase
      end
   end

   tdq_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_work   (push_work)
   );

   tdq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_work  (push_work),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_work   (pop_work)
   );

   tdq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .pop_work    (pop_work),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- sv/tdq_checker.sv -----
// tdq_checker: port-level checks of the dither quantiser, bound to the top level
// depends on tdq_pkg and tpdf_dither_quantizer
module tdq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input tdq_pkg::rsp_type               rsp_payload,
   input logic                           csr_ready
);

   // a waiting result transaction holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   a_csr_open: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("register port blocked");

   // input back-pressure only follows a stalled result
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> $past(rsp_valid && !rsp_ready))
      else $error("input stalled without output stall");

endmodule

bind tpdf_dither_quantizer tdq_checker u_checker (.*);
